>>> rtl/core/flp_pkg.sv
// Shared types and constants for the FIR low-pass filter unit.
// Used by the tap cells, the MAC stage, the top level and the checker.
// Depends on nothing.
package flp_pkg;

    // Default sizes; the top level takes them as parameter defaults
    localparam int TAPS_DEF        = 101;
    localparam int SAMPLE_BITS_DEF = 16;

    // Width of the coefficient index field in the input beat
    localparam int COEF_IDX_W = 7;

    // Input beat kind, carried in tuser
    typedef enum logic {
        CMD_SAMPLE = 1'b0,
        CMD_LOAD   = 1'b1
    } t_cmd;

    // Sequencer states
    typedef enum logic [1:0] {
        ST_IDLE,
        ST_RUN,
        ST_WAIT
    } t_state;

    // Movement controls broadcast to every tap cell
    typedef struct packed {
        logic shift;   // history moves one place toward the old end
        logic rotate;  // history and weight move one place toward cell 0
    } t_cell_ctl;

    // Tag that travels with each operand pair into the MAC
    typedef struct packed {
        logic valid;
        logic first;   // tap 0: start a new sum
        logic last;    // final tap: sum is complete after this one
    } t_mac_tag;

endpackage

>>> rtl/core/flp_tap_cell.sv
// One tap of the filter: holds one history sample and one weight.
// Depends on flp_pkg (t_cell_ctl).
module flp_tap_cell
    import flp_pkg::*;
#(
    parameter int SAMPLE_BITS = SAMPLE_BITS_DEF
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  t_cell_ctl                     i_ctl,
    input  logic                          i_load,
    input  logic signed [SAMPLE_BITS-1:0] i_load_coef,
    input  logic signed [SAMPLE_BITS-1:0] i_hist_prev,
    input  logic signed [SAMPLE_BITS-1:0] i_hist_next,
    input  logic signed [SAMPLE_BITS-1:0] i_coef_next,
    output logic signed [SAMPLE_BITS-1:0] o_hist,
    output logic signed [SAMPLE_BITS-1:0] o_coef
);

    logic signed [SAMPLE_BITS-1:0] r_hist;
    logic signed [SAMPLE_BITS-1:0] r_coef;

    // History: cleared at reset, shifts on a new sample, rotates during a pass
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_hist <= '0;
        end else if (i_ctl.shift) begin
            r_hist <= i_hist_prev;
        end else if (i_ctl.rotate) begin
            r_hist <= i_hist_next;
        end
    end

    // Weight: loaded by address, rotates along with the history
    always_ff @(posedge i_clk) begin
        if (i_load) begin
            r_coef <= i_load_coef;
        end else if (i_ctl.rotate) begin
            r_coef <= i_coef_next;
        end
    end

    assign o_hist = r_hist;
    assign o_coef = r_coef;

endmodule

>>> rtl/core/flp_mac.sv
// Multiply-accumulate with per-step clamping, then round and saturate.
// Depends on flp_pkg (t_mac_tag).
module flp_mac
    import flp_pkg::*;
#(
    parameter int SAMPLE_BITS = SAMPLE_BITS_DEF
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  t_mac_tag                      i_tag,
    input  logic signed [SAMPLE_BITS-1:0] i_hist,
    input  logic signed [SAMPLE_BITS-1:0] i_coef,
    input  logic                          i_take,
    output logic                          o_done,
    output logic        [SAMPLE_BITS-1:0] o_result,
    output logic                          o_sat
);

    localparam int FRAC = SAMPLE_BITS - 1;
    localparam int PW   = 2 * SAMPLE_BITS;       // product and accumulator
    localparam int SW   = PW + 1;                // sum before clamping
    localparam int QW   = SW - FRAC;             // rounded value

    localparam logic signed [SW-1:0] ACC_MAX =
        signed'({2'b00, 1'b1, {(PW - 2){1'b0}}});
    localparam logic signed [SW-1:0] ACC_MIN = -ACC_MAX;
    localparam logic signed [SW-1:0] RND_HALF =
        signed'({{(SW - FRAC){1'b0}}, 1'b1, {(FRAC - 1){1'b0}}});

    logic signed [PW-1:0] r_prod;
    t_mac_tag             r_tag;
    logic signed [PW-1:0] r_acc;
    logic                 r_done;
    logic signed [PW-1:0] n_acc;
    logic signed [SW-1:0] w_sum;
    logic signed [SW-1:0] w_rnd;
    logic signed [QW-1:0] w_q;
    logic                 w_fits;

    // Stage 1: product register
    always_ff @(posedge i_clk) begin
        r_prod <= PW'(i_hist) * PW'(i_coef);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_tag <= '0;
        end else begin
            r_tag <= i_tag;
        end
    end

    // Stage 2: accumulate and clamp to the accumulator bound
    always_comb begin
        w_sum = r_tag.first ? SW'(r_prod) : (SW'(r_acc) + SW'(r_prod));
        if (w_sum > ACC_MAX) begin
            n_acc = ACC_MAX[PW-1:0];
        end else if (w_sum < ACC_MIN) begin
            n_acc = ACC_MIN[PW-1:0];
        end else begin
            n_acc = w_sum[PW-1:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_tag.valid) begin
            r_acc <= n_acc;
        end
    end

    // Sum-ready flag, held until the output register takes the result
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_done <= 1'b0;
        end else if (r_tag.valid && r_tag.last) begin
            r_done <= 1'b1;
        end else if (i_take) begin
            r_done <= 1'b0;
        end
    end

    // Round half up, drop fraction, saturate to the sample range
    always_comb begin
        w_rnd  = SW'(r_acc) + RND_HALF;
        w_q    = QW'(w_rnd >>> FRAC);
        w_fits = (w_q[QW-1:SAMPLE_BITS-1] == '0) || (w_q[QW-1:SAMPLE_BITS-1] == '1);
        o_sat  = !w_fits;
        if (w_fits) begin
            o_result = w_q[SAMPLE_BITS-1:0];
        end else if (w_q[QW-1]) begin
            o_result = {1'b1, {(SAMPLE_BITS - 1){1'b0}}};
        end else begin
            o_result = {1'b0, {(SAMPLE_BITS - 1){1'b1}}};
        end
    end

    assign o_done = r_done;

endmodule

>>> rtl/core/fir_lowpass_filter_unit.sv
// Top level of the direct-form FIR low-pass filter.
// Depends on flp_pkg, flp_tap_cell and flp_mac.
//
// Usage:
//   Input stream (s_axis_*): tuser selects the beat kind. A sample beat
//   (tuser = 0) carries a Q1.15 sample in tdata and yields one result. A
//   load beat (tuser = 1) writes one tap weight at coef_index and yields no
//   result; an index at or past TAPS is ignored. Weights must be loaded
//   before the first sample that uses them.
//   Output stream (m_axis_*): tdata is the rounded, saturated Q1.15 output,
//   tuser is set when the sum was clipped.
//   Timing: a load beat is taken in the idle state and starts no pass. A
//   sample beat shifts the history in the cycle it is taken, then the
//   weight/history ring rotates past the single multiplier once, one tap per
//   cycle. The input stays closed from a sample beat until its result is
//   taken into the output register, so the multiplier and the ring rotation
//   set the sample rate. Reset clears the sample history and all handshake
//   state; weights are not cleared. A stalled receiver holds the output
//   beat; the next sample runs meanwhile and waits at the end of its pass
//   until the output frees.
module fir_lowpass_filter_unit
    import flp_pkg::*;
#(
    parameter int TAPS        = TAPS_DEF,
    parameter int SAMPLE_BITS = SAMPLE_BITS_DEF,
    localparam int IN_W  = ((2 * SAMPLE_BITS + COEF_IDX_W + 7) / 8) * 8,
    localparam int OUT_W = ((SAMPLE_BITS + 7) / 8) * 8
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             s_axis_tvalid,
    output logic             s_axis_tready,
    input  logic [IN_W-1:0]  s_axis_tdata,   // sample, coef_index, coef_value
    input  logic             s_axis_tuser,   // cmd
    output logic             m_axis_tvalid,
    input  logic             m_axis_tready,
    output logic [OUT_W-1:0] m_axis_tdata,   // filtered_sample
    output logic             m_axis_tuser    // saturated
);

    localparam int TAP_W = (TAPS > 1) ? $clog2(TAPS) : 1;
    localparam int CMP_W = ((TAP_W > COEF_IDX_W) ? TAP_W : COEF_IDX_W) + 1;
    localparam logic [TAP_W-1:0] LAST_TAP = TAP_W'(TAPS - 1);

    // Input beat fields
    logic signed [SAMPLE_BITS-1:0] w_sample;
    logic        [COEF_IDX_W-1:0]  w_coef_idx;
    logic signed [SAMPLE_BITS-1:0] w_coef_val;
    t_cmd                          w_cmd;

    assign w_sample   = s_axis_tdata[SAMPLE_BITS-1:0];
    assign w_coef_idx = s_axis_tdata[SAMPLE_BITS+COEF_IDX_W-1:SAMPLE_BITS];
    assign w_coef_val = s_axis_tdata[2*SAMPLE_BITS+COEF_IDX_W-1:SAMPLE_BITS+COEF_IDX_W];
    assign w_cmd      = t_cmd'(s_axis_tuser);

    t_state             r_state;
    t_state             n_state;
    logic [TAP_W-1:0]   r_cnt;
    logic [TAP_W-1:0]   n_cnt;
    logic               w_accept;
    logic               w_load;
    logic               w_take;
    t_cell_ctl          w_ctl;
    t_mac_tag           w_tag;

    logic signed [SAMPLE_BITS-1:0] w_hist [TAPS];
    logic signed [SAMPLE_BITS-1:0] w_coef [TAPS];

    logic                   w_done;
    logic [SAMPLE_BITS-1:0] w_result;
    logic                   w_sat;

    logic                   r_ovalid;
    logic [SAMPLE_BITS-1:0] r_odata;
    logic                   r_osat;

    assign w_accept = s_axis_tvalid && s_axis_tready;
    assign w_take   = w_done && (!r_ovalid || m_axis_tready);

    // Next state
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            ST_IDLE: begin
                if (w_accept && (w_cmd == CMD_SAMPLE)) begin
                    n_state = ST_RUN;
                end
            end
            ST_RUN: begin
                if (r_cnt == LAST_TAP) begin
                    n_state = ST_WAIT;
                end
            end
            ST_WAIT: begin
                if (w_take) begin
                    n_state = ST_IDLE;
                end
            end
            default: n_state = ST_IDLE;
        endcase
    end

    // State outputs
    always_comb begin
        s_axis_tready = 1'b0;
        w_ctl         = '0;
        w_tag         = '0;
        w_load        = 1'b0;
        n_cnt         = r_cnt;
        unique case (r_state)
            ST_IDLE: begin
                s_axis_tready = 1'b1;
                w_ctl.shift   = w_accept && (w_cmd == CMD_SAMPLE);
                w_load        = w_accept && (w_cmd == CMD_LOAD);
                n_cnt         = '0;
            end
            ST_RUN: begin
                w_ctl.rotate = 1'b1;
                w_tag.valid  = 1'b1;
                w_tag.first  = (r_cnt == '0);
                w_tag.last   = (r_cnt == LAST_TAP);
                n_cnt        = (r_cnt == LAST_TAP) ? '0 : r_cnt + 1'b1;
            end
            ST_WAIT: begin
                n_cnt = '0;
            end
            default: begin
                n_cnt = '0;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
            r_cnt   <= '0;
        end else begin
            r_state <= n_state;
            r_cnt   <= n_cnt;
        end
    end

    // Ring of tap cells: shift toward the old end, rotate toward cell 0
    for (genvar k = 0; k < TAPS; k++) begin : g_tap
        logic signed [SAMPLE_BITS-1:0] w_prev;
        logic                          w_sel;

        assign w_prev = (k == 0) ? w_sample : w_hist[(k == 0) ? 0 : k - 1];
        assign w_sel  = w_load && (CMP_W'(w_coef_idx) == CMP_W'(k));

        flp_tap_cell #(
            .SAMPLE_BITS (SAMPLE_BITS)
        ) u_cell (
            .i_clk       (i_clk),
            .i_rst_n     (i_rst_n),
            .i_ctl       (w_ctl),
            .i_load      (w_sel),
            .i_load_coef (w_coef_val),
            .i_hist_prev (w_prev),
            .i_hist_next (w_hist[(k + 1) % TAPS]),
            .i_coef_next (w_coef[(k + 1) % TAPS]),
            .o_hist      (w_hist[k]),
            .o_coef      (w_coef[k])
        );
    end

    // Single MAC fed from cell 0
    flp_mac #(
        .SAMPLE_BITS (SAMPLE_BITS)
    ) u_mac (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_tag    (w_tag),
        .i_hist   (w_hist[0]),
        .i_coef   (w_coef[0]),
        .i_take   (w_take),
        .o_done   (w_done),
        .o_result (w_result),
        .o_sat    (w_sat)
    );

    // Output beat register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ovalid <= 1'b0;
        end else if (w_take) begin
            r_ovalid <= 1'b1;
        end else if (m_axis_tready) begin
            r_ovalid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_take) begin
            r_odata <= w_result;
            r_osat  <= w_sat;
        end
    end

    assign m_axis_tvalid = r_ovalid;
    assign m_axis_tdata  = OUT_W'(r_odata);
    assign m_axis_tuser  = r_osat;

endmodule

>>> rtl/core/flp_checker.sv
// Port-level checks for the FIR low-pass filter unit, bound to the top level.
// Depends on flp_pkg (t_cmd, defaults).
module flp_checker
    import flp_pkg::*;
#(
    parameter int SAMPLE_BITS = SAMPLE_BITS_DEF,
    localparam int OUT_W = ((SAMPLE_BITS + 7) / 8) * 8
) (
    input logic             i_clk,
    input logic             i_rst_n,
    input logic             s_axis_tvalid,
    input logic             s_axis_tready,
    input logic             s_axis_tuser,   // cmd
    input logic             m_axis_tvalid,
    input logic             m_axis_tready,
    input logic [OUT_W-1:0] m_axis_tdata,   // filtered_sample
    input logic             m_axis_tuser    // saturated
);

    localparam logic [SAMPLE_BITS-1:0] MAX_CODE = {1'b0, {(SAMPLE_BITS - 1){1'b1}}};
    localparam logic [SAMPLE_BITS-1:0] MIN_CODE = {1'b1, {(SAMPLE_BITS - 1){1'b0}}};

    // A stalled output beat holds
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (m_axis_tvalid && !m_axis_tready) |=>
            (m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tuser)))
        else $error("output beat changed while stalled");

    // A sample beat starts a pass, so the input closes in the next cycle
    a_busy_after_sample: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (s_axis_tvalid && s_axis_tready && (t_cmd'(s_axis_tuser) == CMD_SAMPLE))
            |=> !s_axis_tready)
        else $error("input still open after a sample beat");

    // A new result only comes out of a running pass
    a_result_from_pass: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(m_axis_tvalid) |-> $past(!s_axis_tready))
        else $error("result appeared without a pass");

    // Clipped results sit at one of the two extreme codes
    a_sat_code: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (m_axis_tvalid && m_axis_tuser) |->
            ((m_axis_tdata[SAMPLE_BITS-1:0] == MAX_CODE) ||
             (m_axis_tdata[SAMPLE_BITS-1:0] == MIN_CODE)))
        else $error("saturated flag with an in-range code");

endmodule

bind fir_lowpass_filter_unit flp_checker #(
    .SAMPLE_BITS (SAMPLE_BITS)
) u_flp_checker (.*);

>>> dv/fir_lowpass_filter_unit_tb.sv
// Self-checking testbench for fir_lowpass_filter_unit: weight loads, sample beats,
// saturation and accumulator clamping under random source idling and sink stalls.
// Depends on flp_pkg and the fir_lowpass_filter_unit RTL.
`timescale 1ns / 100ps

module fir_lowpass_filter_unit_tb;
    import flp_pkg::*;

    localparam int TAPS        = TAPS_DEF;
    localparam int SAMPLE_BITS = SAMPLE_BITS_DEF;
    localparam int IN_W  = ((2 * SAMPLE_BITS + COEF_IDX_W + 7) / 8) * 8;
    localparam int OUT_W = ((SAMPLE_BITS + 7) / 8) * 8;

    localparam int  CLK_HALF_NS    = 10;
    localparam int  RX_HOLD_CYCLES = 800;
    // Run limit for the whole test, in ns
    localparam longint TIMEOUT_NS  = 64'd24_000_000;

    typedef struct {
        logic [15:0] value;
        logic        sat;
    } t_fir_result;

    logic             i_clk         = 1'b0;
    logic             i_rst_n       = 1'b0;
    logic             s_axis_tvalid = 1'b0;
    logic             s_axis_tready;
    logic [IN_W-1:0]  s_axis_tdata  = '0;  // sample, coef_index, coef_value
    logic             s_axis_tuser  = 1'b0; // cmd
    logic             m_axis_tvalid;
    logic             m_axis_tready = 1'b0;
    logic [OUT_W-1:0] m_axis_tdata;        // filtered_sample
    logic             m_axis_tuser;        // saturated

    // Filter state mirrored at beat acceptance
    logic signed [15:0] hist_model   [TAPS];
    logic signed [15:0] weight_model [TAPS];
    t_fir_result        pending_outputs[$];

    int tx_idle_pct   = 0;
    int rx_stall_pct  = 0;
    int hold_requests = 0;
    int hold_served   = 0;
    int fail_count    = 0;

    fir_lowpass_filter_unit #(
        .TAPS        (TAPS),
        .SAMPLE_BITS (SAMPLE_BITS)
    ) u_dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser)
    );

    // Clock
    initial begin
        forever #(CLK_HALF_NS) i_clk = ~i_clk;
    end

    // Run limit
    initial begin
        #(TIMEOUT_NS);
        $display("tb: failure");
        $finish;
    end

    // Sink: random stalls, plus long hold-offs on request
    initial begin
        forever begin
            @(posedge i_clk);
            if (hold_served != hold_requests) begin
                m_axis_tready <= 1'b0;
                repeat (RX_HOLD_CYCLES - 1) @(posedge i_clk);
                hold_served++;
            end else begin
                m_axis_tready <= ($urandom_range(99) >= rx_stall_pct);
            end
        end
    end

    // Output check against the oldest pending result
    always @(posedge i_clk) begin
        t_fir_result exp_res;
        if (i_rst_n && m_axis_tvalid && m_axis_tready) begin
            if (pending_outputs.size() == 0) begin
                $display("%0t: unexpected output beat: tdata %h tuser %b",
                         $time, m_axis_tdata, m_axis_tuser);
                fail_count++;
            end else begin
                exp_res = pending_outputs.pop_front();
                if (m_axis_tdata[15:0] !== exp_res.value) begin
                    $display("%0t: filtered_sample mismatch: expected %h actual %h",
                             $time, exp_res.value, m_axis_tdata[15:0]);
                    fail_count++;
                end
                if (m_axis_tuser !== exp_res.sat) begin
                    $display("%0t: saturated mismatch: expected %b actual %b",
                             $time, exp_res.sat, m_axis_tuser);
                    fail_count++;
                end
            end
        end
    end

    // Update the mirrored state for an accepted beat; a sample beat queues its result
    function automatic void record_beat(input t_cmd cmd, input logic [15:0] smp,
                                        input logic [COEF_IDX_W-1:0] idx,
                                        input logic [15:0] wgt);
        longint      acc;
        longint      rnd;
        longint      acc_lim;
        t_fir_result res;
        acc_lim = longint'(1) <<< (2 * SAMPLE_BITS - 2);
        if (cmd == CMD_LOAD) begin
            if (idx < TAPS)
                weight_model[idx] = wgt;
        end else begin
            for (int k = TAPS - 1; k > 0; k--)
                hist_model[k] = hist_model[k-1];
            hist_model[0] = smp;
            // Running sum, clamped after every tap
            acc = 0;
            for (int k = 0; k < TAPS; k++) begin
                acc = acc + longint'(weight_model[k]) * longint'(hist_model[k]);
                if (acc > acc_lim)
                    acc = acc_lim;
                else if (acc < -acc_lim)
                    acc = -acc_lim;
            end
            // Round half up, back to Q1.15, then saturate
            rnd = (acc + (longint'(1) <<< (SAMPLE_BITS - 2))) >>> (SAMPLE_BITS - 1);
            res.sat = 1'b0;
            if (rnd > 32767) begin
                rnd     = 32767;
                res.sat = 1'b1;
            end else if (rnd < -32768) begin
                rnd     = -32768;
                res.sat = 1'b1;
            end
            res.value = rnd[15:0];
            pending_outputs.push_back(res);
        end
    endfunction

    // Offer one beat, with an optional idle gap first, and wait for the handshake
    task automatic send_beat(input t_cmd cmd, input logic [15:0] smp,
                             input logic [COEF_IDX_W-1:0] idx, input logic [15:0] wgt);
        int gap;
        if ($urandom_range(99) < tx_idle_pct) begin
            // gap length spread over a whole filter pass
            gap = $urandom_range(1, TAPS + 8);
            s_axis_tvalid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tuser  <= cmd;
        s_axis_tdata  <= IN_W'({wgt, idx, smp});
        @(posedge i_clk);
        while (!s_axis_tready)
            @(posedge i_clk);
        record_beat(cmd, smp, idx, wgt);
    endtask

    // Source pauses until every pending result is out
    task automatic wait_for_outputs();
        s_axis_tvalid <= 1'b0;
        @(posedge i_clk);
        while (pending_outputs.size() != 0)
            @(posedge i_clk);
    endtask

    // Write every tap; small weights keep most sums in range
    task automatic load_weight_table(input bit with_extremes);
        logic [15:0] wgt;
        for (int k = 0; k < TAPS; k++) begin
            wgt = 16'($urandom_range(0, 1023)) - 16'd512;
            if (with_extremes && k == 0)
                wgt = 16'h7fff;
            else if (with_extremes && k == TAPS - 1)
                wgt = 16'h8000;
            send_beat(CMD_LOAD, 16'($urandom), COEF_IDX_W'(k), wgt);
        end
        wait_for_outputs();
    endtask

    task automatic test_directed_cases();
        tx_idle_pct  = 0;
        rx_stall_pct = 0;
        // sample extremes and small values
        send_beat(CMD_SAMPLE, 16'h7fff, '0, '0);
        send_beat(CMD_SAMPLE, 16'h8000, '0, '0);
        send_beat(CMD_SAMPLE, 16'h0000, '0, '0);
        send_beat(CMD_SAMPLE, 16'hffff, '0, '0);
        send_beat(CMD_SAMPLE, 16'h0001, '0, '0);
        // loads past the last tap are dropped
        send_beat(CMD_LOAD, 16'h1234, COEF_IDX_W'(TAPS), 16'h7fff);
        send_beat(CMD_LOAD, 16'h4321, '1, 16'h8000);
        send_beat(CMD_SAMPLE, 16'h4000, '1, 16'hffff);
        // clip high, then clip low
        send_beat(CMD_LOAD, 16'h0000, COEF_IDX_W'(1), 16'h7fff);
        send_beat(CMD_LOAD, 16'h0000, COEF_IDX_W'(2), 16'h7fff);
        repeat (3) send_beat(CMD_SAMPLE, 16'h7fff, '0, '0);
        repeat (3) send_beat(CMD_SAMPLE, 16'h8000, '0, '0);
        // full-scale negative operands give full-scale products that hit the sum bound
        send_beat(CMD_LOAD, 16'h0000, COEF_IDX_W'(0), 16'h8000);
        send_beat(CMD_LOAD, 16'h0000, COEF_IDX_W'(1), 16'h8000);
        send_beat(CMD_LOAD, 16'h0000, COEF_IDX_W'(2), 16'h8000);
        repeat (3) send_beat(CMD_SAMPLE, 16'h8000, '0, '0);
        wait_for_outputs();
    endtask

    // Mostly samples, some weight updates, a few loads out of range
    task automatic send_random_beat();
        logic [15:0]           smp;
        logic [15:0]           wgt;
        logic [COEF_IDX_W-1:0] idx;
        int                    pick;
        int                    sel;
        pick = $urandom_range(99);
        sel  = $urandom_range(9);
        smp  = 16'($urandom);
        wgt  = 16'($urandom);
        idx  = COEF_IDX_W'($urandom);
        if (pick < 85) begin
            if (sel < 2)
                smp = sel[0] ? 16'h7fff : 16'h8000;
            else if (sel < 4)
                smp = 16'($urandom_range(0, 255)) - 16'd128;
            send_beat(CMD_SAMPLE, smp, idx, wgt);
        end else begin
            idx = (pick < 98) ? COEF_IDX_W'($urandom_range(0, TAPS - 1))
                              : COEF_IDX_W'($urandom_range(TAPS, 127));
            if (sel < 7)
                wgt = 16'($urandom_range(0, 2047)) - 16'd1024;
            send_beat(CMD_LOAD, smp, idx, wgt);
        end
    endtask

    task automatic test_random_traffic(input int count, input int tx_pct, input int rx_pct);
        tx_idle_pct  = tx_pct;
        rx_stall_pct = rx_pct;
        repeat (count) send_random_beat();
        wait_for_outputs();
    endtask

    // Sink holds off while samples keep coming, so the input backs up
    task automatic test_output_backpressure();
        tx_idle_pct  = 0;
        rx_stall_pct = 0;
        hold_requests++;
        repeat (24) send_beat(CMD_SAMPLE, 16'($urandom), COEF_IDX_W'($urandom), 16'($urandom));
        while (hold_served != hold_requests)
            @(posedge i_clk);
        wait_for_outputs();
    endtask

    // Test sequence
    initial begin
        for (int k = 0; k < TAPS; k++) begin
            hist_model[k]   = '0;
            weight_model[k] = '0;
        end
        repeat (8) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        load_weight_table(1'b1);
        test_directed_cases();
        load_weight_table(1'b0);
        test_random_traffic(320, 0, 0);
        test_random_traffic(300, 86, 0);
        test_output_backpressure();
        load_weight_table(1'b0);
        test_random_traffic(300, 0, 86);
        test_random_traffic(300, 25, 25);

        wait_for_outputs();
        repeat (TAPS + 8) @(posedge i_clk);
        if (fail_count == 0)
            $display("tb: success");
        else
            $display("tb: failure");
        $finish;
    end

endmodule
